// ----- rtl/pctb_pkg.sv -----
// ----------------------------------------------------------------------------
// pctb_pkg
// Shared types, register map and helpers for the prescaled compare timer bank.
// ----------------------------------------------------------------------------
package pctb_pkg;

    // Bank size limits
    localparam int MAX_TIMERS = 8;
    localparam int SLOT_COUNT = 8;

    // Stream widths: tdata = {elapsed, write_value, reg_offset}, padded to bytes
    localparam int OFFSET_W    = 6;
    localparam int VALUE_W     = 32;
    localparam int ELAPSED_W   = 16;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;

    // Tick scaling and divider
    localparam int          SCALED_W   = 22;
    localparam int          DIVIDEND_W = 33;
    localparam int          DIV_STEPS  = 33;
    localparam int          STEP_W     = 6;
    localparam logic [5:0]  TICK_SCALE = 6'd50;

    // Register map offsets
    localparam logic [OFFSET_W-1:0] OFF_IE      = 6'd0;
    localparam logic [OFFSET_W-1:0] OFF_IF      = 6'd1;
    localparam logic [OFFSET_W-1:0] OFF_REPEAT  = 6'd2;
    localparam logic [OFFSET_W-1:0] OFF_COUNT   = 6'd10;
    localparam logic [OFFSET_W-1:0] OFF_DIVIDER = 6'd18;
    localparam logic [OFFSET_W-1:0] OFF_ENABLED = 6'd26;
    localparam logic [OFFSET_W-1:0] OFF_COMPARE = 6'd34;
    localparam logic [OFFSET_W-1:0] OFF_END     = 6'd42;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // Register regions
    typedef enum logic [2:0] {
        RG_IE,
        RG_IF,
        RG_REPEAT,
        RG_COUNT,
        RG_DIVIDER,
        RG_ENABLED,
        RG_COMPARE,
        RG_NONE
    } region_t;

    typedef struct packed {
        region_t    region;
        logic [2:0] slot;
    } reg_sel_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_T_CHECK,
        ST_T_DIV,
        ST_T_UPDATE,
        ST_FINISH
    } state_t;

    // Split a bus offset into region and per-timer slot
    function automatic reg_sel_t decode_offset(input logic [OFFSET_W-1:0] off);
        reg_sel_t            sel;
        logic [OFFSET_W-1:0] rel;
        sel.region = RG_NONE;
        sel.slot   = 3'd0;
        rel        = '0;
        if (off == OFF_IE) begin
            sel.region = RG_IE;
        end else if (off == OFF_IF) begin
            sel.region = RG_IF;
        end else if (off < OFF_COUNT) begin
            sel.region = RG_REPEAT;
            rel        = off - OFF_REPEAT;
        end else if (off < OFF_DIVIDER) begin
            sel.region = RG_COUNT;
            rel        = off - OFF_COUNT;
        end else if (off < OFF_ENABLED) begin
            sel.region = RG_DIVIDER;
            rel        = off - OFF_DIVIDER;
        end else if (off < OFF_COMPARE) begin
            sel.region = RG_ENABLED;
            rel        = off - OFF_ENABLED;
        end else if (off < OFF_END) begin
            sel.region = RG_COMPARE;
            rel        = off - OFF_COMPARE;
        end
        sel.slot = rel[2:0];
        return sel;
    endfunction

endpackage

// ----- rtl/prescaled_compare_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// prescaled_compare_timer_bank_core
// Bank of prescaled compare timers behind a small register map, driven by a
// stream of tick, read and write commands; one result word per command.
// ----------------------------------------------------------------------------
// One command word goes in, one result word comes out. A read or write passes
// from acceptance through the execute and finish states into the output
// register. A tick visits the timers one at a time; each timer that is enabled
// with a nonzero divider runs a 33-step restoring divider (one quotient bit
// per cycle) that is shared by the whole bank, followed by an update step. The
// input is not ready while a command is in work; the result sits in an output
// register, so the next command may be taken before the result is consumed.
module prescaled_compare_timer_bank_core #(
    parameter int NUM_TIMERS = pctb_pkg::MAX_TIMERS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] reg_offset, [37:6] write_value, [53:38] elapsed, [55:54] zero
    input  logic [pctb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [pctb_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] read_data
    output logic [pctb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] irq
    output logic [pctb_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import pctb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Sequencer
    state_t                 state_reg;
    state_t                 state_next;
    logic [IDX_W-1:0]       tmr_reg;
    logic [STEP_W-1:0]      step_reg;

    // Latched command word
    cmd_t                   cmd_reg;
    logic [OFFSET_W-1:0]    off_reg;
    logic [VALUE_W-1:0]     wval_reg;
    logic [SCALED_W-1:0]    scaled_reg;
    logic [VALUE_W-1:0]     rd_reg;

    // Shared divider
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [VALUE_W-1:0]     rem_reg;

    // Timer bank state
    logic [7:0]             ie_reg;
    logic [7:0]             if_reg;
    logic [NUM_TIMERS-1:0]  rep_reg;
    logic [NUM_TIMERS-1:0]  en_reg;
    logic [VALUE_W-1:0]     count_reg [NUM_TIMERS];
    logic [VALUE_W-1:0]     div_reg   [NUM_TIMERS];
    logic [VALUE_W-1:0]     cmp_reg   [NUM_TIMERS];
    logic [VALUE_W-1:0]     res_reg   [NUM_TIMERS];

    // Output register
    logic                   m_valid_reg;
    logic [VALUE_W-1:0]     m_data_reg;
    logic                   m_irq_reg;

    // Combinational helpers
    logic                   in_accept;
    logic                   out_free;
    reg_sel_t               sel;
    logic                   slot_ok;
    logic [IDX_W-1:0]       acc_idx;
    logic [VALUE_W-1:0]     div_cur;
    logic [VALUE_W-1:0]     bus_rdata;
    logic                   active;
    logic                   last_tmr;
    logic [DIVIDEND_W-1:0]  trial;
    logic [DIVIDEND_W-1:0]  diff;
    logic                   trial_ge;
    logic [VALUE_W-1:0]     cnt_sum;
    logic                   fire;
    logic [7:0]             flag_bit;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Address decode and the single bank access index
    assign sel      = decode_offset(off_reg);
    assign slot_ok  = ({1'b0, sel.slot} < 4'(NUM_TIMERS));
    assign acc_idx  = (state_reg == ST_EXEC) ? sel.slot[IDX_W-1:0] : tmr_reg;
    assign div_cur  = div_reg[acc_idx];
    assign active   = en_reg[acc_idx] && (div_cur != '0);
    assign last_tmr = (tmr_reg == IDX_W'(NUM_TIMERS - 1));
    assign flag_bit = 8'(1) << tmr_reg;

    // Register read mux
    always_comb
    begin
        bus_rdata = '0;
        case (sel.region)
            RG_IE:      bus_rdata = {24'd0, ie_reg};
            RG_IF:      bus_rdata = {24'd0, if_reg};
            RG_REPEAT:  bus_rdata = slot_ok ? {31'd0, rep_reg[acc_idx]} : '0;
            RG_COUNT:   bus_rdata = slot_ok ? count_reg[acc_idx] : '0;
            RG_DIVIDER: bus_rdata = slot_ok ? div_cur : '0;
            RG_ENABLED: bus_rdata = slot_ok ? {31'd0, en_reg[acc_idx]} : '0;
            RG_COMPARE: bus_rdata = slot_ok ? cmp_reg[acc_idx] : '0;
            default:    bus_rdata = '0;
        endcase
    end

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, div_cur};
    assign trial_ge = (trial >= {1'b0, div_cur});

    // Count update after the divide
    assign cnt_sum = count_reg[acc_idx] + quo_reg[VALUE_W-1:0];
    assign fire    = (cnt_sum >= cmp_reg[acc_idx]);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (cmd_reg == CMD_TICK) ? ST_T_CHECK : ST_FINISH;
            end
            ST_T_CHECK:
            begin
                if (active)
                begin
                    state_next = ST_T_DIV;
                end
                else if (last_tmr)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_T_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_T_UPDATE;
                end
            end
            ST_T_UPDATE:
            begin
                state_next = last_tmr ? ST_FINISH : ST_T_CHECK;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command latch, sequencing counters and divider datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmr_reg  <= '0;
            step_reg <= '0;
            cmd_reg  <= CMD_TICK;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    tmr_reg  <= '0;
                    step_reg <= '0;
                    if (in_accept)
                    begin
                        cmd_reg <= cmd_t'(s_axis_tuser);
                    end
                end
                ST_T_CHECK:
                begin
                    step_reg <= '0;
                    if (!active && !last_tmr)
                    begin
                        tmr_reg <= tmr_reg + 1'b1;
                    end
                end
                ST_T_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                ST_T_UPDATE:
                begin
                    if (!last_tmr)
                    begin
                        tmr_reg <= tmr_reg + 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
        end
    end

    // Payload registers of the command and the divider
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            off_reg    <= s_axis_tdata[OFFSET_W-1:0];
            wval_reg   <= s_axis_tdata[OFFSET_W +: VALUE_W];
            scaled_reg <= SCALED_W'(s_axis_tdata[OFFSET_W+VALUE_W +: ELAPSED_W])
                          * SCALED_W'(TICK_SCALE);
        end
        if (state_reg == ST_EXEC)
        begin
            rd_reg <= (cmd_reg == CMD_READ) ? bus_rdata : '0;
        end
        if (state_reg == ST_T_CHECK)
        begin
            quo_reg <= {1'b0, res_reg[acc_idx]} + DIVIDEND_W'(scaled_reg);
            rem_reg <= '0;
        end
        else if (state_reg == ST_T_DIV)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], trial_ge};
            rem_reg <= trial_ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
        end
    end

    // Timer bank: bus writes and tick updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ie_reg  <= '0;
            if_reg  <= '0;
            rep_reg <= '0;
            en_reg  <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= '0;
                div_reg[i]   <= '0;
                cmp_reg[i]   <= '0;
                res_reg[i]   <= '0;
            end
        end
        else if (state_reg == ST_EXEC && cmd_reg == CMD_WRITE)
        begin
            case (sel.region)
                RG_IE:      ie_reg <= wval_reg[7:0];
                RG_IF:      if_reg <= wval_reg[7:0];
                RG_REPEAT:
                begin
                    if (slot_ok) rep_reg[acc_idx] <= (wval_reg != '0);
                end
                RG_COUNT:
                begin
                    if (slot_ok) count_reg[acc_idx] <= wval_reg;
                end
                RG_DIVIDER:
                begin
                    if (slot_ok) div_reg[acc_idx] <= wval_reg;
                end
                RG_ENABLED:
                begin
                    if (slot_ok) en_reg[acc_idx] <= (wval_reg != '0);
                end
                RG_COMPARE:
                begin
                    if (slot_ok) cmp_reg[acc_idx] <= wval_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_T_UPDATE)
        begin
            res_reg[acc_idx] <= rem_reg;
            if (fire)
            begin
                count_reg[acc_idx] <= '0;
                if_reg             <= if_reg | flag_bit;
                if (!rep_reg[acc_idx])
                begin
                    en_reg[acc_idx] <= 1'b0;
                end
            end
            else
            begin
                count_reg[acc_idx] <= cnt_sum;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            m_data_reg <= rd_reg;
            m_irq_reg  <= ((ie_reg & if_reg) != '0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_irq_reg;

`ifndef SYNTHESIS
    // Divider remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_DIV) |-> (rem_reg < div_cur))
        else $error("divider remainder not below divisor");

    // Divide runs only with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_DIV) |-> (div_cur != '0))
        else $error("divide started with zero divisor");

    // A compare match raises that timer's flag
    a_fire_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_UPDATE && fire) |=> ((if_reg & $past(flag_bit)) != '0))
        else $error("compare match did not set flag");

    // Every accepted word is decoded in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");
`endif

endmodule

// ----- verif/prescaled_compare_timer_bank_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prescaled_compare_timer_bank_core_test
// Drives tick, read and write command words into the timer bank and checks
// every result word (read data and irq) against a cycle-free model of the
// register file and timers kept inside the bench. A directed opener covers
// field extremes and corner cases; the random body sets timers up with small
// dividers and compares so that they expire often, with noise mixed in.
// ----------------------------------------------------------------------------
module prescaled_compare_timer_bank_core_test;

    import pctb_pkg::*;

    localparam int          TIMER_COUNT   = MAX_TIMERS;
    localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
    localparam int          RANDOM_ITEMS  = 1750;
    localparam int          HOLD_AT_WORD  = 300;
    localparam int          HOLD_CYCLES   = 800;
    localparam int          DRAIN_CYCLES  = 300;
    localparam int          REPLY_SLOTS   = 64;

    typedef struct {
        logic [31:0] read_data;
        logic        irq;
    } reply_t;

    // ------------------------------------------------------------------------
    // Model of the bank: register state plus the ring of result words due
    // ------------------------------------------------------------------------
    class timer_bank_mirror;
        logic [7:0]  ie_mask;
        logic [7:0]  flag_mask;
        logic        repeat_q   [TIMER_COUNT];
        logic        enabled_q  [TIMER_COUNT];
        logic [31:0] count_q    [TIMER_COUNT];
        logic [31:0] divider_q  [TIMER_COUNT];
        logic [31:0] compare_q  [TIMER_COUNT];
        logic [31:0] residue_q  [TIMER_COUNT];
        reply_t      due_ring   [REPLY_SLOTS];
        int          due_head, due_tail, due_count;
        int          errors;
        int          checked;
        int          n_tick, n_read, n_write, n_other, n_expiry;

        function new();
            ie_mask   = '0;
            flag_mask = '0;
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                repeat_q[t]  = 1'b0;
                enabled_q[t] = 1'b0;
                count_q[t]   = '0;
                divider_q[t] = '0;
                compare_q[t] = '0;
                residue_q[t] = '0;
            end
            due_head  = 0;
            due_tail  = 0;
            due_count = 0;
            errors    = 0;
            checked   = 0;
            n_tick    = 0;
            n_read    = 0;
            n_write   = 0;
            n_other   = 0;
            n_expiry  = 0;
        endfunction

        // Per-timer register window: true when off falls on a present timer
        function bit in_bank(logic [5:0] off, logic [5:0] base, output int slot);
            slot = int'(off) - int'(base);
            return (off >= base) && (slot < TIMER_COUNT);
        endfunction

        // One tick: prescale, count, compare, flag
        function void advance_timers(logic [15:0] el);
            logic [32:0] total;
            logic [32:0] quot;
            for (int t = 0; t < TIMER_COUNT; t++)
            begin
                if (divider_q[t] == 0 || !enabled_q[t])
                    continue;
                total        = {1'b0, residue_q[t]} + 33'(el) * 33'(TICK_SCALE);
                quot         = total / {1'b0, divider_q[t]};
                count_q[t]   = count_q[t] + quot[31:0];
                residue_q[t] = 32'(total % {1'b0, divider_q[t]});
                if (count_q[t] >= compare_q[t])
                begin
                    count_q[t]   = '0;
                    flag_mask[t] = 1'b1;
                    n_expiry++;
                    if (!repeat_q[t])
                        enabled_q[t] = 1'b0;
                end
            end
        endfunction

        function logic [31:0] read_reg(logic [5:0] off);
            int s;
            if (off == OFF_IE) return {24'd0, ie_mask};
            if (off == OFF_IF) return {24'd0, flag_mask};
            if (in_bank(off, OFF_REPEAT, s))  return {31'd0, repeat_q[s]};
            if (in_bank(off, OFF_COUNT, s))   return count_q[s];
            if (in_bank(off, OFF_DIVIDER, s)) return divider_q[s];
            if (in_bank(off, OFF_ENABLED, s)) return {31'd0, enabled_q[s]};
            if (in_bank(off, OFF_COMPARE, s)) return compare_q[s];
            return '0;
        endfunction

        function void write_reg(logic [5:0] off, logic [31:0] val);
            int s;
            if (off == OFF_IE)                     ie_mask      = val[7:0];
            else if (off == OFF_IF)                flag_mask    = val[7:0];
            else if (in_bank(off, OFF_REPEAT, s))  repeat_q[s]  = (val != 0);
            else if (in_bank(off, OFF_COUNT, s))   count_q[s]   = val;
            else if (in_bank(off, OFF_DIVIDER, s)) divider_q[s] = val;
            else if (in_bank(off, OFF_ENABLED, s)) enabled_q[s] = (val != 0);
            else if (in_bank(off, OFF_COMPARE, s)) compare_q[s] = val;
        endfunction

        // Accepted command word: update state, queue the result it owes
        function void apply_command(logic [1:0] cmd, logic [5:0] off,
                                    logic [31:0] val, logic [15:0] el);
            reply_t r;
            r.read_data = '0;
            case (cmd)
                CMD_TICK:
                begin
                    advance_timers(el);
                    n_tick++;
                end
                CMD_READ:
                begin
                    r.read_data = read_reg(off);
                    n_read++;
                end
                CMD_WRITE:
                begin
                    write_reg(off, val);
                    n_write++;
                end
                default:
                    n_other++;
            endcase
            r.irq = |(ie_mask & flag_mask);
            if (due_count == REPLY_SLOTS)
            begin
                errors++;
                $display("%0t: too many result words outstanding", $time);
                return;
            end
            due_ring[due_tail] = r;
            due_tail = (due_tail + 1) % REPLY_SLOTS;
            due_count++;
        endfunction

        // Result word from the block against the oldest one due
        function void compare_reply(logic [31:0] data, logic irq_bit);
            reply_t want;
            if (due_count == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, read_data %h irq %b",
                         $time, data, irq_bit);
                return;
            end
            want = due_ring[due_head];
            due_head = (due_head + 1) % REPLY_SLOTS;
            due_count--;
            checked++;
            if (data !== want.read_data)
            begin
                errors++;
                $display("%0t: read_data mismatch, expected %h actual %h",
                         $time, want.read_data, data);
            end
            if (irq_bit !== want.irq)
            begin
                errors++;
                $display("%0t: irq mismatch, expected %b actual %b",
                         $time, want.irq, irq_bit);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    timer_bank_mirror mirror = new();
    int               sent_count = 0;

    prescaled_compare_timer_bank_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Handshake monitors: command words into the model, result words checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                mirror.apply_command(s_axis_tuser, s_axis_tdata[5:0],
                                     s_axis_tdata[37:6], s_axis_tdata[53:38]);
            if (m_axis_tvalid && m_axis_tready)
                mirror.compare_reply(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int got;
        int stall;
        got = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (got == HOLD_AT_WORD)
                stall = HOLD_CYCLES;
            else if ((got / 48) % 3 == 2)
                stall = 0;
            else
                stall = int'($urandom_range(0, 19));
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            got++;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] cmd, input logic [5:0] off,
                             input logic [31:0] val, input logic [15:0] el);
        int gap;
        gap = ((sent_count / 64) % 3 == 1) ? 0 : int'($urandom_range(0, 19));
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, el, val, off};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        sent_count++;
    endtask

    // Write data shaped by the register it lands in, so timers actually run
    function automatic logic [31:0] shaped_value(logic [5:0] off);
        int r;
        r = int'($urandom_range(0, 99));
        if (off >= OFF_DIVIDER && off < OFF_ENABLED)
            return (r < 10) ? 32'd0 : (r < 75) ? $urandom_range(1, 64) :
                   (r < 90) ? $urandom_range(65, 100000) : $urandom();
        if (off >= OFF_COMPARE && off < OFF_END)
            return (r < 10) ? 32'd0 : (r < 70) ? $urandom_range(1, 200) : $urandom();
        if (off >= OFF_COUNT && off < OFF_DIVIDER)
            return (r < 50) ? $urandom_range(0, 100) : $urandom();
        if ((off >= OFF_REPEAT && off < OFF_COUNT) || (off >= OFF_ENABLED && off < OFF_COMPARE))
            return (r < 30) ? 32'd1 : (r < 65) ? $urandom() : 32'd0;
        return (r < 50) ? $urandom_range(0, 255) : $urandom();
    endfunction

    task automatic send_random();
        int          pick;
        int          r;
        logic [1:0]  cmd;
        logic [5:0]  off;
        logic [31:0] val;
        logic [15:0] el;
        pick = int'($urandom_range(0, 99));
        r    = int'($urandom_range(0, 99));
        off  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(OFF_END, 63))
                                           : 6'($urandom_range(0, OFF_END - 1));
        val  = $urandom();
        el   = (r < 50) ? 16'($urandom_range(0, 40))
             : (r < 80) ? 16'($urandom_range(0, 2000))
                        : 16'($urandom_range(0, 65535));
        if (pick < 35)
            cmd = CMD_TICK;
        else if (pick < 62)
            cmd = CMD_READ;
        else if (pick < 96)
        begin
            cmd = CMD_WRITE;
            val = shaped_value(off);
        end
        else
            cmd = CMD_UNKNOWN;
        send_word(cmd, off, val, el);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, mask truncation, nonzero-as-one
        send_word(CMD_READ,  OFF_IE,              32'd0,          16'd0);
        send_word(CMD_READ,  6'(OFF_COMPARE + 7), 32'd0,          16'd0);
        send_word(CMD_WRITE, OFF_IE,              32'hFFFF_FF81,  16'd0);
        send_word(CMD_READ,  OFF_IE,              32'd0,          16'd0);
        send_word(CMD_WRITE, OFF_DIVIDER,         32'd1,          16'd0);
        send_word(CMD_WRITE, OFF_ENABLED,         32'h8000_0000,  16'd0);
        // zero compare fires even on a zero-length tick; one-shot drops out
        send_word(CMD_TICK,  6'd0,                32'd0,          16'd0);
        send_word(CMD_READ,  OFF_IF,              32'd0,          16'd0);
        send_word(CMD_WRITE, OFF_IF,              32'd0,          16'd0);
        // timer 7: max divider, max compare, max count, repeat mode
        send_word(CMD_WRITE, 6'(OFF_REPEAT + 7),  32'h0000_0100,  16'd0);
        send_word(CMD_WRITE, 6'(OFF_DIVIDER + 7), 32'hFFFF_FFFF,  16'd0);
        send_word(CMD_WRITE, 6'(OFF_ENABLED + 7), 32'd1,          16'd0);
        send_word(CMD_WRITE, 6'(OFF_COMPARE + 7), 32'hFFFF_FFFF,  16'd0);
        send_word(CMD_WRITE, 6'(OFF_COUNT + 7),   32'hFFFF_FFFF,  16'd0);
        send_word(CMD_TICK,  6'h3F,               32'hFFFF_FFFF,  16'hFFFF);
        // smaller divider keeps the old residue; count then wraps past zero
        send_word(CMD_WRITE, 6'(OFF_DIVIDER + 7), 32'd7,          16'd0);
        send_word(CMD_WRITE, 6'(OFF_COUNT + 7),   32'hFFFF_FFF0,  16'd0);
        send_word(CMD_TICK,  6'd0,                32'd0,          16'd1);
        send_word(CMD_READ,  6'(OFF_COUNT + 7),   32'd0,          16'd0);
        // unmapped offsets and the unused command code
        send_word(CMD_WRITE, OFF_END,             32'hDEAD_BEEF,  16'd0);
        send_word(CMD_WRITE, 6'h3F,               32'hFFFF_FFFF,  16'd0);
        send_word(CMD_READ,  6'h3F,               32'd0,          16'd0);
        send_word(CMD_UNKNOWN, OFF_IE,            32'hFFFF_FFFF,  16'hFFFF);
        send_word(CMD_READ,  OFF_ENABLED,         32'd0,          16'd0);
        send_word(CMD_READ,  6'(OFF_DIVIDER + 7), 32'd0,          16'd0);

        repeat (RANDOM_ITEMS) send_random();
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a full tick's worth of cycles for strays
        while (mirror.checked < sent_count) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d ticks, %0d reads, %0d writes, %0d unused commands;",
                 mirror.n_tick, mirror.n_read, mirror.n_write, mirror.n_other);
        $display("%0d timer expiries modeled, %0d result words checked, %0d errors.",
                 mirror.n_expiry, mirror.checked, mirror.errors);
        if (mirror.errors == 0 && mirror.due_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
